// ===== src/svcv_pkg.sv =====
// Shared types and constants for the sliding-window class vote block.
package svcv_pkg;

  localparam int unsigned WindowDepth = 64;
  localparam int unsigned NumClasses  = 8;
  localparam int unsigned ScoreBits   = 16;

  localparam int unsigned SlotW   = $clog2(WindowDepth);
  localparam int unsigned ClassW  = $clog2(NumClasses);
  localparam int unsigned CountW  = SlotW + 1;
  localparam int unsigned CcW     = 4;
  localparam int unsigned PctW    = 7;
  localparam int unsigned SumW    = ScoreBits + SlotW;
  localparam int unsigned StoreAw = SlotW + ClassW;

  localparam logic [1:0] CfgWindowLength  = 2'd0;
  localparam logic [1:0] CfgClassCount    = 2'd1;
  localparam logic [1:0] CfgMinVotePct    = 2'd2;

  localparam logic [CountW-1:0] WindowLengthRst = CountW'(50);
  localparam logic [CcW-1:0]    ClassCountRst   = CcW'(8);
  localparam logic [PctW-1:0]   MinVotePctRst   = PctW'(20);

  typedef struct packed {
    logic                        action;
    logic signed [ScoreBits-1:0] score;
  } in_t;

  typedef struct packed {
    logic [ClassW-1:0] best_class;
    logic              unknown;
    logic [CountW-1:0] top_votes;
    logic [CountW-1:0] window_fill;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DROP_RD, ST_DROP_UPD, ST_TRIM, ST_SCAN, ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic write;
    logic drop_upd;
    logic drop_done;
    logic vote;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic drop_first;
    logic last_elem;
    logic trim_need;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

// ===== src/sliding_window_class_vote_core.sv =====
// Top level of the sliding-window class vote block.
// Scores arrive one class per item; class_count items make a frame, and a
// frame-ending item yields one result (the class with the largest summed
// score over the last window_length frames, its top vote count, the fill, and
// an unknown flag when the top vote share is below min_vote_percent).
// Steps: a mid-frame score item is accepted in idle and then executed
// before the next acceptance; a clear item takes the same path. A
// frame-ending item adds the trim check with the vote step, a scan of one
// class per cycle and an emit step. Each oldest frame retired, the full
// storage at a frame start or a full window at a frame end, adds a read step
// and an update step for each class, since frame storage has one read port
// and retiring a frame reads its scores back one class at a time.
// The result sits in an output register, so the next item is taken while it
// waits; the next frame end holds in its emit cycle until that result leaves.
// Configuration is taken at any time with ready held high; writing
// class_count empties the window. No clearing pass after reset.
module sliding_window_class_vote_core import svcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  svcv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svcv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // a result never reports an empty window
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.window_fill != '0 && out_item_o.top_votes != '0))
    else $error("result with empty window");

  a_votes_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.top_votes <= out_item_o.window_fill))
    else $error("top votes exceed window fill");

  // one item at a time: after taking an item the input is stalled
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while busy");

endmodule

// ===== src/svcv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module svcv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/svcv_ctrl.sv =====
// Controller state machine for the class vote block.
module svcv_ctrl import svcv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   trim_q, trim_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      trim_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      trim_q  <= trim_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    trim_d     = trim_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else if (status_i.drop_first) begin
          trim_d  = 1'b0;
          state_d = ST_DROP_RD;
        end else begin
          cmd_o.write = 1'b1;
          state_d     = status_i.last_elem ? ST_TRIM : ST_IDLE;
        end
      end
      ST_DROP_RD: state_d = ST_DROP_UPD;
      ST_DROP_UPD: begin
        cmd_o.drop_upd = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.drop_done = 1'b1;
          state_d         = trim_q ? ST_TRIM : ST_EXEC;
        end else begin
          state_d = ST_DROP_RD;
        end
      end
      ST_TRIM: begin
        if (status_i.trim_need) begin
          trim_d  = 1'b1;
          state_d = ST_DROP_RD;
        end else begin
          cmd_o.vote = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.idx_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/svcv_dp.sv =====
// Datapath: window storage, running sums and votes, argmax scan, output register.
module svcv_dp import svcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_t        in_item_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_t       out_item_o
);

  logic [CountW-1:0] wl_q;
  logic [CcW-1:0]    cc_q;
  logic [PctW-1:0]   pct_q;

  in_t                      item_q;
  logic signed [SumW-1:0]   sum_q [NumClasses];
  logic [CountW-1:0]        vote_q [NumClasses];
  logic [SlotW-1:0]         oldest_q;
  logic [CountW-1:0]        held_q;
  logic [ClassW-1:0]        pos_q;
  logic [ClassW-1:0]        cnt_q;
  logic signed [ScoreBits-1:0] top_score_q;
  logic [ClassW-1:0]        top_class_q;
  logic [ClassW-1:0]        best_q;
  logic signed [SumW-1:0]   bsum_q;
  logic [CountW-1:0]        btop_q;
  logic                     out_valid_q;
  out_t                     out_q;

  logic [CountW-1:0]        eff_win;
  logic [CcW-1:0]           eff_cc;
  logic [SlotW-1:0]         slot;
  logic signed [ScoreBits-1:0] store_rdata;
  logic [ClassW-1:0]        winner_rdata;
  logic                     wipe;
  logic                     idx_last;
  logic [13:0]              lhs, rhs;

  assign eff_win = (wl_q == '0) ? CountW'(1) :
                   (wl_q > CountW'(WindowDepth)) ? CountW'(WindowDepth) : wl_q;
  assign eff_cc  = (cc_q == '0) ? CcW'(1) :
                   (cc_q > CcW'(NumClasses)) ? CcW'(NumClasses) : cc_q;
  assign slot     = oldest_q + held_q[SlotW-1:0];
  assign idx_last = ({1'b0, cnt_q} + CcW'(1)) >= eff_cc;
  assign wipe     = cmd_i.clear || (cfg_we_i && cfg_index_i == CfgClassCount);

  assign status_o.is_clear   = item_q.action;
  assign status_o.drop_first = (pos_q == '0) && (held_q >= CountW'(WindowDepth));
  assign status_o.last_elem  = ({1'b0, pos_q} + CcW'(1)) >= eff_cc;
  assign status_o.trim_need  = (held_q != '0) && (held_q >= eff_win);
  assign status_o.idx_last   = idx_last;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  svcv_ram #(.Width(ScoreBits), .Depth(WindowDepth * NumClasses)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i ({slot, pos_q}),
    .wdata_i (item_q.score),
    .raddr_i ({oldest_q, cnt_q}),
    .rdata_o (store_rdata)
  );

  svcv_ram #(.Width(ClassW), .Depth(WindowDepth)) u_winner (
    .clk_i   (clk_i),
    .we_i    (cmd_i.vote),
    .waddr_i (slot),
    .wdata_i (top_class_q),
    .raddr_i (oldest_q),
    .rdata_o (winner_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.emit) out_q <= '{best_class: best_q, unknown: lhs < rhs,
                               top_votes: btop_q, window_fill: held_q};
  end

  assign lhs = 14'(btop_q) * 14'd100;
  assign rhs = 14'(pct_q) * 14'(held_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q        <= WindowLengthRst;
      cc_q        <= ClassCountRst;
      pct_q       <= MinVotePctRst;
      for (int i = 0; i < NumClasses; i++) begin
        sum_q[i]  <= '0;
        vote_q[i] <= '0;
      end
      oldest_q    <= '0;
      held_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      top_score_q <= '0;
      top_class_q <= '0;
      best_q      <= '0;
      bsum_q      <= '0;
      btop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgWindowLength: wl_q  <= cfg_data_i;
          CfgClassCount:   cc_q  <= cfg_data_i[CcW-1:0];
          CfgMinVotePct:   pct_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (wipe) begin
        for (int i = 0; i < NumClasses; i++) begin
          sum_q[i]  <= '0;
          vote_q[i] <= '0;
        end
        oldest_q    <= '0;
        held_q      <= '0;
        pos_q       <= '0;
        cnt_q       <= '0;
        top_score_q <= '0;
        top_class_q <= '0;
      end

      if (cmd_i.write) begin
        sum_q[pos_q] <= sum_q[pos_q] + SumW'(item_q.score);
        if (pos_q == '0 || item_q.score > top_score_q) begin
          top_score_q <= item_q.score;
          top_class_q <= pos_q;
        end
        if (!status_o.last_elem) pos_q <= pos_q + ClassW'(1);
      end

      // retire one element of the oldest frame
      if (cmd_i.drop_upd) begin
        sum_q[cnt_q] <= sum_q[cnt_q] - SumW'(store_rdata);
        if (cnt_q == '0 && vote_q[winner_rdata] != '0)
          vote_q[winner_rdata] <= vote_q[winner_rdata] - CountW'(1);
        cnt_q <= idx_last ? '0 : cnt_q + ClassW'(1);
      end
      if (cmd_i.drop_done) begin
        oldest_q <= oldest_q + SlotW'(1);
        held_q   <= held_q - CountW'(1);
      end

      if (cmd_i.vote) begin
        vote_q[top_class_q] <= vote_q[top_class_q] + CountW'(1);
        held_q <= held_q + CountW'(1);
        pos_q  <= '0;
        cnt_q  <= '0;
      end

      // argmax over sums, max over votes, one class per cycle
      if (cmd_i.scan) begin
        if (cnt_q == '0) begin
          best_q <= '0;
          bsum_q <= sum_q[0];
          btop_q <= vote_q[0];
        end else begin
          if (sum_q[cnt_q] > bsum_q) begin
            best_q <= cnt_q;
            bsum_q <= sum_q[cnt_q];
          end
          if (vote_q[cnt_q] > btop_q) btop_q <= vote_q[cnt_q];
        end
        cnt_q <= idx_last ? '0 : cnt_q + ClassW'(1);
      end

      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sim/sliding_window_class_vote_core_tb.sv =====
// Testbench for the sliding-window class vote block: directed table, then random frames.
module sliding_window_class_vote_core_tb;
  import svcv_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_t        in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_t       out_item_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [6:0] cfg_data_i;

  sliding_window_class_vote_core DUT (.*);

  localparam int WatchLimit = 20000;
  localparam int PendDepth  = 64;
  localparam int MaxRows    = 32;

  // Predictor state: window contents and running tallies.
  int unsigned win_len, cls_cnt, min_pct;
  logic signed [ScoreBits-1:0] held_score [WindowDepth][NumClasses];
  int unsigned held_vote [WindowDepth];
  longint sum_by_class [NumClasses];
  int unsigned votes_by_class [NumClasses];
  int unsigned head_slot, fill, elem_pos, lead_class;
  int          lead_score;

  // Expected results waiting for the block, oldest at pend_rd.
  out_t        pend_mem [PendDepth];
  int unsigned pend_wr = 0;
  int unsigned pend_rd = 0;
  out_t        last_pred;
  int          errors = 0;
  bit          stim_done;
  int          idle_cycles = 0;

  // Directed rows: act, score, has_exp, expected result.
  typedef struct {
    bit   act;
    int   score;
    bit   has_exp;
    out_t exp;
  } row_t;

  row_t rows [MaxRows];
  int   n_rows = 0;

  function automatic void add_row(bit act, int score, bit has_exp, out_t want);
    rows[n_rows] = '{act, score, has_exp, want};
    n_rows++;
  endfunction

  function automatic void pend_add(out_t r);
    pend_mem[pend_wr % PendDepth] = r;
    pend_wr++;
  endfunction

  function automatic out_t pend_take();
    out_t r;
    r = pend_mem[pend_rd % PendDepth];
    pend_rd++;
    return r;
  endfunction

  function automatic int unsigned pend_count();
    return pend_wr - pend_rd;
  endfunction

  function automatic int unsigned eff_win();
    if (win_len == 0) return 1;
    if (win_len > WindowDepth) return WindowDepth;
    return win_len;
  endfunction

  function automatic int unsigned eff_cls();
    if (cls_cnt == 0) return 1;
    if (cls_cnt > NumClasses) return NumClasses;
    return cls_cnt;
  endfunction

  function automatic void empty_window();
    for (int c = 0; c < NumClasses; c++) begin
      sum_by_class[c] = 0;
      votes_by_class[c] = 0;
    end
    head_slot = 0; fill = 0; elem_pos = 0; lead_score = 0; lead_class = 0;
  endfunction

  function automatic void retire_oldest();
    if (fill == 0) return;
    for (int c = 0; c < eff_cls(); c++) sum_by_class[c] -= held_score[head_slot][c];
    if (votes_by_class[held_vote[head_slot]] > 0) votes_by_class[held_vote[head_slot]]--;
    head_slot = (head_slot + 1) % WindowDepth;
    fill--;
  endfunction

  // Applies one item; records the expected result when a frame completes.
  function automatic void predict_vote(in_t it);
    int unsigned pos, slot, best, top;
    longint      best_sum;
    out_t        r;
    if (it.action) begin
      empty_window();
      return;
    end
    pos = elem_pos;
    if (pos >= eff_cls()) pos = 0;
    if (pos == 0 && fill >= WindowDepth) retire_oldest();
    slot = (head_slot + fill) % WindowDepth;
    held_score[slot][pos] = it.score;
    if (pos == 0 || int'(it.score) > lead_score) begin
      lead_score = it.score;
      lead_class = pos;
    end
    if (pos + 1 < eff_cls()) begin
      elem_pos = pos + 1;
      return;
    end
    while (fill > 0 && fill >= eff_win()) retire_oldest();
    slot = (head_slot + fill) % WindowDepth;
    for (int c = 0; c < eff_cls(); c++) sum_by_class[c] += held_score[slot][c];
    held_vote[slot] = lead_class;
    votes_by_class[lead_class]++;
    fill++;
    elem_pos = 0;
    best = 0; best_sum = sum_by_class[0]; top = votes_by_class[0];
    for (int c = 1; c < eff_cls(); c++) begin
      if (sum_by_class[c] > best_sum) begin
        best_sum = sum_by_class[c];
        best = c;
      end
      if (votes_by_class[c] > top) top = votes_by_class[c];
    end
    r.best_class  = ClassW'(best);
    r.unknown     = (top * 100 < min_pct * fill);
    r.top_votes   = CountW'(top);
    r.window_fill = CountW'(fill);
    last_pred = r;
    pend_add(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("sliding_window_class_vote_core verification failed");
        $finish;
      end
    end
  end

  // Result checker and random receiver stall.
  initial begin
    int unsigned hold;
    out_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pend_count() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          want = pend_take();
          if (out_item_o.best_class != want.best_class)
            report_mismatch("best_class", out_item_o.best_class, want.best_class);
          if (out_item_o.unknown != want.unknown)
            report_mismatch("unknown", out_item_o.unknown, want.unknown);
          if (out_item_o.top_votes != want.top_votes)
            report_mismatch("top_votes", out_item_o.top_votes, want.top_votes);
          if (out_item_o.window_fill != want.window_fill)
            report_mismatch("window_fill", out_item_o.window_fill, want.window_fill);
        end
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (stim_done) hold = $urandom_range(0, 2);
        @(negedge clk_i);
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Sends one item with a random leading gap (none when busy is set), then waits for acceptance.
  // Valid stays high after acceptance so a zero gap gives back-to-back items.
  task automatic send_item(input bit act, input int score, input bit busy);
    in_t it;
    int unsigned gap;
    it.action = act;
    it.score  = score[ScoreBits-1:0];
    gap = busy ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_vote(it);
  endtask

  // Drops input valid after the last item of a run.
  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits for all expected results plus settling, then writes a register.
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    while (pend_count() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[6:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgWindowLength: win_len = val & 7'h7f;
      CfgClassCount: begin
        cls_cnt = val & 4'hf;
        empty_window();
      end
      default: min_pct = val & 7'h7f;
    endcase
  endtask

  // Random frames; mostly whole frames, with the odd clear or partial frame.
  task automatic random_phase(input int unsigned n_items);
    int unsigned sent, k;
    int s;
    bit busy;
    sent = 0;
    busy = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 40) == 0) begin
        send_item(1'b1, $urandom, busy);
      end else begin
        k = $urandom_range(0, 5);
        case (k)
          0: s = $urandom_range(0, 1) ? 32767 : -32768;
          1: s = $urandom_range(0, 3);
          default: s = $signed(16'($urandom));
        endcase
        send_item(1'b0, s, busy);
      end
      sent++;
      if ($urandom_range(0, 30) == 0) busy = !busy;
    end
    release_input();
  endtask

  initial begin
    out_t e;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgWindowLength;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    stim_done   = 0;
    win_len = WindowLengthRst;
    cls_cnt = ClassCountRst;
    min_pct = MinVotePctRst;
    empty_window();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // After reset: 8 classes. A frame with class 3 on top gives class 3,
    // one vote of one frame, known at 20 percent.
    e = '{best_class: 3'd3, unknown: 1'b0, top_votes: 7'd1, window_fill: 7'd1};
    for (int c = 0; c < 8; c++)
      add_row(1'b0, (c == 3) ? 32767 : -32768, c == 7, e);
    // Clear in mid frame drops the partial frame.
    add_row(1'b0, 100, 1'b0, '0);
    add_row(1'b1, -1, 1'b0, '0);
    // All-equal frame: first class wins on ties.
    e = '{best_class: 3'd0, unknown: 1'b0, top_votes: 7'd1, window_fill: 7'd1};
    for (int c = 0; c < 8; c++) add_row(1'b0, 0, c == 7, e);
    // Second frame of extremes, checked by the predictor.
    for (int c = 0; c < 8; c++) add_row(1'b0, (c == 6) ? 32767 : -1, 1'b0, '0);
    for (int i = 0; i < n_rows; i++) begin
      send_item(rows[i].act, rows[i].score, 0);
      if (rows[i].has_exp && last_pred != rows[i].exp)
        report_mismatch("directed row", i, 0);
    end
    release_input();

    random_phase(150);
    // Small window and classes, percent above one hundred.
    write_reg(CfgClassCount, 3);
    write_reg(CfgWindowLength, 1);
    write_reg(CfgMinVotePct, 127);
    random_phase(80);
    // Zero registers act as one; percent zero.
    write_reg(CfgClassCount, 0);
    write_reg(CfgWindowLength, 0);
    write_reg(CfgMinVotePct, 0);
    random_phase(40);
    // Oversize values clamp; full depth, with a later shrink.
    write_reg(CfgClassCount, 15);
    write_reg(CfgWindowLength, 127);
    write_reg(CfgMinVotePct, 100);
    random_phase(60);
    write_reg(CfgClassCount, 2);
    write_reg(CfgMinVotePct, 50);
    random_phase(150);
    write_reg(CfgWindowLength, 5);
    random_phase(80);
    write_reg(CfgWindowLength, 64);
    write_reg(CfgClassCount, 5);
    random_phase(60);

    stim_done = 1;
    while (pend_count() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0)
      $display("sliding_window_class_vote_core verification clean");
    else
      $display("sliding_window_class_vote_core verification failed");
    $finish;
  end

endmodule
